// ===== rtl/core/lcd_status_line_compare_unit_macros.svh =====
// Assertion macros used by the LCD status line-compare RTL.
`ifndef LCD_STATUS_LINE_COMPARE_UNIT_MACROS_SVH
`define LCD_STATUS_LINE_COMPARE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSLC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LSLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lcdslc_pkg.sv =====
// Types and constants for the LCD status line-compare unit.
`timescale 1ns / 1ps
package lcdslc_pkg;

  typedef enum logic [1:0] {
    CMD_REG_WRITE   = 2'd0,
    CMD_MODE_CHANGE = 2'd1,
    CMD_LINE_DONE   = 2'd2,
    CMD_FRAME_START = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    SEL_CONTROL  = 2'd0,
    SEL_STATUS   = 2'd1,
    SEL_LINE_CNT = 2'd2,
    SEL_LINE_CMP = 2'd3
  } reg_sel_e;

  typedef enum logic [1:0] {
    MODE_HBLANK   = 2'd0,
    MODE_VBLANK   = 2'd1,
    MODE_OAM_READ = 2'd2,
    MODE_TRANSFER = 2'd3
  } lcd_mode_e;

  // Control register bit.
  localparam int unsigned CtrlLcdOnBit = 7;

  // Status register bits.
  localparam int unsigned StatMatchBit    = 2;
  localparam int unsigned StatHblankIeBit = 3;
  localparam int unsigned StatVblankIeBit = 4;
  localparam int unsigned StatOamIeBit    = 5;
  localparam int unsigned StatMatchIeBit  = 6;

  // Status bits that a bus write may change.
  localparam logic [7:0] StatWriteMask = 8'hf8;

  typedef struct packed {
    cmd_e       command;
    reg_sel_e   reg_select;
    logic [7:0] write_data;
    lcd_mode_e  mode_value;
  } in_beat_t;

  typedef struct packed {
    logic       stat_interrupt;
    logic       vblank_interrupt;
    logic [7:0] status_value;
    logic [7:0] line_count;
    lcd_mode_e  effective_mode;
    logic [7:0] control_value;
  } out_beat_t;

endpackage

// ===== rtl/core/lcd_status_line_compare_unit.sv =====
// LCD status, line count and line compare registers with interrupt generation.
`timescale 1ns / 1ps
`include "lcd_status_line_compare_unit_macros.svh"

// Each input beat is a register write, a mode change, a line-finished event or a
// frame-start event; each produces exactly one output beat carrying the interrupt
// requests it raised and the register values after it. The unit accepts one beat
// every clock cycle while the output is not stalled: a beat is captured in an input
// register, and once the output register is free all register updates happen in one
// step while the result is loaded into the output register, where the result beat
// then becomes valid. A stalled output holds the input register, and the input side
// stalls only when both registers are full and the output is not taken.
module lcd_status_line_compare_unit
  import lcdslc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] write_data, [9:8] mode_value, [15:10] zero
  input  logic [15:0] s_axis_tdata_i,
  // [1:0] command, [3:2] reg_select
  input  logic [3:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] stat_interrupt, [1] vblank_interrupt, [9:2] status_value,
  // [17:10] line_count, [19:18] effective_mode, [27:20] control_value, [31:28] zero
  output logic [31:0] m_axis_tdata_o
);

  logic      in_valid_q;
  in_beat_t  in_q;
  logic      out_valid_q;
  out_beat_t out_q, out_d;
  logic      out_free;
  logic      step;
  logic      in_load;

  logic [7:0] ctrl_q, ctrl_d;
  logic [7:0] stat_q, stat_d;
  logic [7:0] lcnt_q, lcnt_d;
  logic [7:0] lcmp_q, lcmp_d;
  logic [7:0] scan_q, scan_d;
  lcd_mode_e  mode_q, mode_d;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign in_load         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q.command    <= cmd_e'(s_axis_tuser_i[1:0]);
      in_q.reg_select <= reg_sel_e'(s_axis_tuser_i[3:2]);
      in_q.write_data <= s_axis_tdata_i[7:0];
      in_q.mode_value <= lcd_mode_e'(s_axis_tdata_i[9:8]);
    end
  end

  always_comb begin
    logic       on;
    logic       match;
    logic       stat_irq;
    logic       vbl_irq;
    logic [7:0] mask;
    logic [7:0] nv;

    on       = ctrl_q[CtrlLcdOnBit];
    match    = 1'b0;
    stat_irq = 1'b0;
    vbl_irq  = 1'b0;
    mask     = 8'h00;
    nv       = stat_q;
    ctrl_d   = ctrl_q;
    stat_d   = stat_q;
    lcnt_d   = lcnt_q;
    lcmp_d   = lcmp_q;
    scan_d   = scan_q;
    mode_d   = mode_q;

    case (in_q.command)
      CMD_REG_WRITE: begin
        case (in_q.reg_select)
          SEL_CONTROL: begin
            // Switching the display off clears the line count.
            if (!in_q.write_data[CtrlLcdOnBit] && on) begin
              lcnt_d = 8'h00;
            end
            ctrl_d = in_q.write_data;
          end
          SEL_STATUS: begin
            // Mode bits are read-only and the match flag is cleared by a write.
            nv = (in_q.write_data & StatWriteMask) | {6'b0, stat_q[1:0]};
            if (on) begin
              stat_irq = (stat_q[1:0] == MODE_HBLANK) || (stat_q[1:0] == MODE_VBLANK);
            end else begin
              nv[1:0] = MODE_HBLANK;
            end
            stat_d = nv;
          end
          SEL_LINE_CNT: begin
            lcnt_d = 8'h00;
          end
          SEL_LINE_CMP: begin
            lcmp_d = in_q.write_data;
          end
          default: begin
            lcmp_d = lcmp_q;
          end
        endcase
      end
      CMD_MODE_CHANGE: begin
        mode_d = on ? in_q.mode_value : MODE_HBLANK;
        nv     = {stat_q[7:2], in_q.mode_value};
        stat_d = nv;
        if (on) begin
          case (in_q.mode_value)
            MODE_OAM_READ: mask[StatOamIeBit] = 1'b1;
            MODE_HBLANK:   mask[StatHblankIeBit] = 1'b1;
            MODE_VBLANK: begin
              mask[StatVblankIeBit] = 1'b1;
              mask[StatOamIeBit]    = 1'b1;
              vbl_irq               = 1'b1;
            end
            default:       mask = 8'h00;
          endcase
          stat_irq = |(nv & mask);
        end
      end
      CMD_LINE_DONE: begin
        match               = on && (scan_q == lcmp_q);
        nv                  = stat_q;
        nv[StatMatchBit]    = match;
        stat_d              = nv;
        stat_irq            = match && stat_q[StatMatchIeBit];
        // The line count restarts at the first line of a frame.
        lcnt_d              = (scan_q == 8'h00) ? 8'h01 : lcnt_q + 8'h01;
        scan_d              = scan_q + 8'h01;
      end
      CMD_FRAME_START: begin
        scan_d = 8'h00;
      end
      default: begin
        scan_d = scan_q;
      end
    endcase

    out_d.stat_interrupt   = stat_irq;
    out_d.vblank_interrupt = vbl_irq;
    out_d.status_value     = stat_d;
    out_d.line_count       = lcnt_d;
    out_d.effective_mode   = ctrl_d[CtrlLcdOnBit] ? mode_d : MODE_HBLANK;
    out_d.control_value    = ctrl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= 8'h00;
      stat_q      <= 8'h00;
      lcnt_q      <= 8'h00;
      lcmp_q      <= 8'h00;
      scan_q      <= 8'h00;
      mode_q      <= MODE_HBLANK;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        ctrl_q <= ctrl_d;
        stat_q <= stat_d;
        lcnt_q <= lcnt_d;
        lcmp_q <= lcmp_d;
        scan_q <= scan_d;
        mode_q <= mode_d;
      end
      if (out_free) begin
        out_valid_q <= step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_q.control_value, out_q.effective_mode,
                            out_q.line_count, out_q.status_value,
                            out_q.vblank_interrupt, out_q.stat_interrupt};

  `LSLC_ASSERT_NOW(a_vbl_mode, out_valid_q && out_q.vblank_interrupt, out_q.status_value[1:0] == MODE_VBLANK, "vblank request without vblank mode")
  `LSLC_ASSERT_NEXT(a_scan_inc, step && (in_q.command == CMD_LINE_DONE), scan_q == 8'($past(scan_q) + 8'h01), "scanline did not advance")
  `LSLC_ASSERT_NEXT(a_frame_clr, step && (in_q.command == CMD_FRAME_START), scan_q == 8'h00, "scanline not cleared at frame start")
  `LSLC_ASSERT_NEXT(a_in_hold, in_valid_q && !step, in_valid_q && $stable(in_q), "input beat lost while stalled")

endmodule

// ===== tb/sv/lcd_status_line_compare_unit_test.sv =====
// Self-checking stream testbench for the LCD status line-compare unit.
`timescale 1ns / 1ps

module lcd_status_line_compare_unit_test;
  import lcdslc_pkg::*;

  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned RandomBeats   = 1850;
  localparam int unsigned DrainCycles   = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [15:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;

  in_beat_t  stimulus_beats[$];
  out_beat_t awaited_results[$];

  // Predicted copy of the LCD registers.
  logic [7:0] ctrl_q = '0;
  logic [7:0] stat_q = '0;
  logic [7:0] ly_q   = '0;
  logic [7:0] lyc_q  = '0;
  logic [7:0] line_q = '0;
  lcd_mode_e  mode_q = MODE_HBLANK;

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;
  int unsigned gap_left     = 0;
  int unsigned burst_left   = 1;
  logic [15:0] rx_pattern   = 16'hffff;
  logic [3:0]  rx_bit       = 4'd0;
  logic        hold_off     = 1'b0;

  lcd_status_line_compare_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #1 clk_i = ~clk_i;

  // Applies one accepted beat to the predicted registers and returns its result.
  task automatic lcd_regs_update(input in_beat_t b, output out_beat_t r);
    logic [7:0] nv;
    logic [7:0] mask;
    logic       lcd_on;
    logic       match;
    r = '0;
    mask = '0;
    lcd_on = ctrl_q[CtrlLcdOnBit];
    case (b.command)
      CMD_REG_WRITE: begin
        case (b.reg_select)
          SEL_CONTROL: begin
            if (!b.write_data[CtrlLcdOnBit] && lcd_on) ly_q = '0;
            ctrl_q = b.write_data;
          end
          SEL_STATUS: begin
            nv = (b.write_data & StatWriteMask) | {6'b0, stat_q[1:0]};
            if (lcd_on) begin
              if (stat_q[1:0] == MODE_HBLANK || stat_q[1:0] == MODE_VBLANK) begin
                r.stat_interrupt = 1'b1;
              end
            end else begin
              nv[1:0] = MODE_HBLANK;
            end
            stat_q = nv;
          end
          SEL_LINE_CNT: ly_q = '0;
          default: lyc_q = b.write_data;
        endcase
      end
      CMD_MODE_CHANGE: begin
        mode_q = lcd_on ? b.mode_value : MODE_HBLANK;
        stat_q[1:0] = b.mode_value;
        if (lcd_on) begin
          case (b.mode_value)
            MODE_OAM_READ: mask[StatOamIeBit] = 1'b1;
            MODE_HBLANK:   mask[StatHblankIeBit] = 1'b1;
            MODE_VBLANK: begin
              mask[StatVblankIeBit] = 1'b1;
              mask[StatOamIeBit] = 1'b1;
              r.vblank_interrupt = 1'b1;
            end
            default: mask = '0;
          endcase
          r.stat_interrupt = |(stat_q & mask);
        end
      end
      CMD_LINE_DONE: begin
        if (line_q == 8'd0) ly_q = '0;
        match = lcd_on && (line_q == lyc_q);
        stat_q[StatMatchBit] = match;
        r.stat_interrupt = stat_q[StatMatchBit] && stat_q[StatMatchIeBit];
        ly_q = ly_q + 8'd1;
        line_q = line_q + 8'd1;
      end
      default: line_q = '0;
    endcase
    r.status_value = stat_q;
    r.line_count = ly_q;
    r.effective_mode = ctrl_q[CtrlLcdOnBit] ? mode_q : MODE_HBLANK;
    r.control_value = ctrl_q;
  endtask

  task automatic add_beat(input cmd_e c, input reg_sel_e s, input logic [7:0] d,
                          input lcd_mode_e m);
    in_beat_t b;
    b.command = c;
    b.reg_select = s;
    b.write_data = d;
    b.mode_value = m;
    stimulus_beats.push_back(b);
  endtask

  // Register writes biased toward a lit display and reachable compare values.
  task automatic add_random_write();
    reg_sel_e   s;
    logic [7:0] d;
    s = reg_sel_e'($urandom_range(0, 3));
    d = 8'($urandom_range(0, 255));
    if (s == SEL_CONTROL && $urandom_range(0, 4) != 0) d[CtrlLcdOnBit] = 1'b1;
    if (s == SEL_LINE_CMP && $urandom_range(0, 3) != 0) d = 8'($urandom_range(0, 20));
    add_beat(CMD_REG_WRITE, s, d, lcd_mode_e'($urandom_range(0, 3)));
  endtask

  task automatic add_noise_beat();
    add_beat(cmd_e'($urandom_range(0, 3)), reg_sel_e'($urandom_range(0, 3)),
             8'($urandom_range(0, 255)), lcd_mode_e'($urandom_range(0, 3)));
  endtask

  task automatic add_event(input cmd_e c, input lcd_mode_e m);
    add_beat(c, reg_sel_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), m);
  endtask

  // One frame of mode changes and finished lines; parts are dropped at random.
  task automatic add_frame();
    int unsigned lines;
    lines = ($urandom_range(0, 29) == 0) ? 260 : $urandom_range(1, 16);
    if ($urandom_range(0, 7) != 0) add_event(CMD_FRAME_START, MODE_HBLANK);
    for (int unsigned i = 0; i < lines; i++) begin
      if (lines < 200) begin
        if ($urandom_range(0, 5) != 0) add_event(CMD_MODE_CHANGE, MODE_OAM_READ);
        if ($urandom_range(0, 5) != 0) add_event(CMD_MODE_CHANGE, MODE_TRANSFER);
        if ($urandom_range(0, 5) != 0) add_event(CMD_MODE_CHANGE, MODE_HBLANK);
        if ($urandom_range(0, 9) == 0) add_random_write();
      end
      add_event(CMD_LINE_DONE, lcd_mode_e'($urandom_range(0, 3)));
    end
    if ($urandom_range(0, 3) != 0) begin
      add_event(CMD_MODE_CHANGE, MODE_VBLANK);
      repeat ($urandom_range(0, 4)) add_event(CMD_LINE_DONE, MODE_VBLANK);
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin : drive_beats
    in_beat_t  cur;
    out_beat_t res;
    logic      offer;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        cur = stimulus_beats.pop_front();
        lcd_regs_update(cur, res);
        awaited_results.push_back(res);
      end
      if (!(s_valid && !s_axis_tready_o)) begin
        offer = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (stimulus_beats.size() != 0) begin
          offer = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        s_valid <= offer;
        if (offer) begin
          s_tdata <= {6'b0, stimulus_beats[0].mode_value, stimulus_beats[0].write_data};
          s_tuser <= {stimulus_beats[0].reg_select, stimulus_beats[0].command};
        end
      end
    end
  end

  // Receiver: checks each result beat and stalls on a rotating random pattern.
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    out_beat_t got;
    out_beat_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_ready) begin
        results_seen++;
        got.stat_interrupt = m_axis_tdata_o[0];
        got.vblank_interrupt = m_axis_tdata_o[1];
        got.status_value = m_axis_tdata_o[9:2];
        got.line_count = m_axis_tdata_o[17:10];
        got.effective_mode = lcd_mode_e'(m_axis_tdata_o[19:18]);
        got.control_value = m_axis_tdata_o[27:20];
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata_o);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("beat %0d: stat_irq %b/%b vbl_irq %b/%b status %h/%h ly %h/%h",
                       results_seen, want.stat_interrupt, got.stat_interrupt,
                       want.vblank_interrupt, got.vblank_interrupt,
                       want.status_value, got.status_value, want.line_count,
                       got.line_count);
              $display("  mode %0d/%0d control %h/%h (expected/actual)",
                       want.effective_mode, got.effective_mode,
                       want.control_value, got.control_value);
            end
          end
        end
      end
      if (rx_bit == 4'd15) begin
        rx_bit = 4'd0;
        rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom | $urandom);
      end else begin
        rx_bit++;
      end
      m_ready <= !hold_off && rx_pattern[rx_bit];
    end
  end

  // A long receiver hold-off so that the unit fills up and stalls its input.
  initial begin
    wait (results_seen >= 400);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // Directed part: display off, then on, every mode and every register.
    add_beat(CMD_REG_WRITE, SEL_CONTROL, 8'h00, MODE_HBLANK);
    add_beat(CMD_REG_WRITE, SEL_STATUS, 8'hff, MODE_TRANSFER);
    add_beat(CMD_MODE_CHANGE, SEL_LINE_CMP, 8'hff, MODE_VBLANK);
    add_beat(CMD_LINE_DONE, SEL_CONTROL, 8'h00, MODE_HBLANK);
    add_beat(CMD_REG_WRITE, SEL_STATUS, 8'h00, MODE_HBLANK);
    add_beat(CMD_REG_WRITE, SEL_CONTROL, 8'hff, MODE_TRANSFER);
    add_beat(CMD_REG_WRITE, SEL_STATUS, 8'h78, MODE_HBLANK);
    add_beat(CMD_REG_WRITE, SEL_LINE_CMP, 8'h00, MODE_HBLANK);
    add_beat(CMD_FRAME_START, SEL_STATUS, 8'hff, MODE_TRANSFER);
    add_beat(CMD_LINE_DONE, SEL_STATUS, 8'h00, MODE_HBLANK);
    add_beat(CMD_LINE_DONE, SEL_CONTROL, 8'hff, MODE_TRANSFER);
    add_beat(CMD_MODE_CHANGE, SEL_CONTROL, 8'h00, MODE_OAM_READ);
    add_beat(CMD_MODE_CHANGE, SEL_CONTROL, 8'h00, MODE_TRANSFER);
    add_beat(CMD_REG_WRITE, SEL_STATUS, 8'hf8, MODE_HBLANK);
    add_beat(CMD_MODE_CHANGE, SEL_CONTROL, 8'h00, MODE_HBLANK);
    add_beat(CMD_MODE_CHANGE, SEL_CONTROL, 8'h00, MODE_VBLANK);
    add_beat(CMD_REG_WRITE, SEL_STATUS, 8'h40, MODE_HBLANK);
    add_beat(CMD_MODE_CHANGE, SEL_CONTROL, 8'h00, MODE_VBLANK);
    add_beat(CMD_REG_WRITE, SEL_LINE_CNT, 8'hff, MODE_HBLANK);
    add_beat(CMD_REG_WRITE, SEL_LINE_CMP, 8'hff, MODE_HBLANK);
    add_beat(CMD_REG_WRITE, SEL_CONTROL, 8'h7f, MODE_HBLANK);
    add_beat(CMD_MODE_CHANGE, SEL_CONTROL, 8'h00, MODE_OAM_READ);
    add_beat(CMD_REG_WRITE, SEL_CONTROL, 8'h80, MODE_HBLANK);
    add_beat(CMD_MODE_CHANGE, SEL_CONTROL, 8'h00, MODE_OAM_READ);
    add_beat(CMD_FRAME_START, SEL_LINE_CMP, 8'hff, MODE_TRANSFER);

    // Random part: mostly frames with random content, some setup and noise.
    while (stimulus_beats.size() < RandomBeats + 25) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 8)) add_noise_beat();
        8: repeat ($urandom_range(1, 4)) add_random_write();
        9: begin
          add_beat(CMD_REG_WRITE, SEL_STATUS, 8'($urandom_range(0, 255)), MODE_HBLANK);
          add_beat(CMD_REG_WRITE, SEL_LINE_CMP, 8'($urandom_range(0, 20)), MODE_HBLANK);
        end
        default: add_frame();
      endcase
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stimulus_beats.size() != 0 || s_valid || awaited_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
